FILE: hdl/cau_pkg.sv
//------------------------------------------------------------------------------
// cau_pkg
// Shared types, opcodes, status codes and helpers of the complex arithmetic
// unit.
//------------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

   // Datapath geometry
   localparam int WORD_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_WIDTH = 2 * WORD_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;
   // Quotient bits needed to tell a valid result from an overflow
   localparam int DIV_STEPS  = WORD_WIDTH + 1;
   localparam int ROOT_BITS  = DIV_STEPS;
   localparam int SQ_IN_BITS = 2 * ROOT_BITS;
   localparam int SQ_REM_W   = WORD_WIDTH + 4;
   localparam int PRE_SHIFT  = DIV_STEPS - FRAC_BITS;
   // Front stages, the divide/root steps and the output register
   localparam int PIPE_LATENCY = 6 + DIV_STEPS;

   // Opcodes
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_SQR = 3'd4;
   localparam logic [2:0] OP_CNJ = 3'd5;
   localparam logic [2:0] OP_MOD = 3'd6;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIVZ = 2'd2;

   localparam logic signed [SUM_WIDTH-1:0] WORD_MAX =
      SUM_WIDTH'((65'sd1 <<< (WORD_WIDTH - 1)) - 65'sd1);
   localparam logic signed [SUM_WIDTH-1:0] WORD_MIN = -WORD_MAX - SUM_WIDTH'(1);

   typedef struct packed {
      logic [2:0]                   req_type;
      logic signed [WORD_WIDTH-1:0] a_real;
      logic signed [WORD_WIDTH-1:0] a_imag;
      logic signed [WORD_WIDTH-1:0] b_real;
      logic signed [WORD_WIDTH-1:0] b_imag;
   } cau_req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] res_real;
      logic signed [WORD_WIDTH-1:0] res_imag;
      logic [1:0]                   status;
   } cau_rsp_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] value;
      logic                  sat;
   } cau_clamp_type;

   // One request as it moves through the divide/root steps
   typedef struct packed {
      logic                    valid;
      logic [2:0]              op;
      logic [WORD_WIDTH-1:0]   dir_re;
      logic [WORD_WIDTH-1:0]   dir_im;
      logic                    dir_sat;
      logic                    div_zero;
      logic                    ovf_re;
      logic                    ovf_im;
      logic                    neg_re;
      logic                    neg_im;
      logic [PROD_WIDTH-1:0]   den;
      logic [PROD_WIDTH-1:0]   rem_re;
      logic [PROD_WIDTH-1:0]   rem_im;
      logic [DIV_STEPS-1:0]    num_re;
      logic [DIV_STEPS-1:0]    num_im;
      logic [DIV_STEPS-1:0]    quo_re;
      logic [DIV_STEPS-1:0]    quo_im;
      logic [SQ_IN_BITS-1:0]   sq_v;
      logic [SQ_REM_W-1:0]     sq_rem;
      logic [ROOT_BITS-1:0]    sq_root;
   } cau_stage_type;

   // Clamp a wide signed value to the word range
   function automatic cau_clamp_type clamp_word(input logic signed [SUM_WIDTH-1:0] v);
      cau_clamp_type c;
      c.value = v[WORD_WIDTH-1:0];
      c.sat   = 1'b0;
      if (v > WORD_MAX) begin
         c.value = WORD_MAX[WORD_WIDTH-1:0];
         c.sat   = 1'b1;
      end else if (v < WORD_MIN) begin
         c.value = WORD_MIN[WORD_WIDTH-1:0];
         c.sat   = 1'b1;
      end
      return c;
   endfunction

   // Signed quotient from magnitude, sign and overflow flag
   function automatic cau_clamp_type quo_word(input logic ovf, input logic neg,
                                              input logic [DIV_STEPS-1:0] q);
      cau_clamp_type c;
      logic [DIV_STEPS-1:0] lim;
      lim = DIV_STEPS'(WORD_MAX[WORD_WIDTH-1:0]);
      if (neg) begin
         if (ovf || q > lim + DIV_STEPS'(1)) begin
            c.value = WORD_MIN[WORD_WIDTH-1:0];
            c.sat   = 1'b1;
         end else begin
            c.value = WORD_WIDTH'(-q);
            c.sat   = 1'b0;
         end
      end else begin
         if (ovf || q > lim) begin
            c.value = WORD_MAX[WORD_WIDTH-1:0];
            c.sat   = 1'b1;
         end else begin
            c.value = q[WORD_WIDTH-1:0];
            c.sat   = 1'b0;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/cau_front.sv
//------------------------------------------------------------------------------
// cau_front
// Input register, products, sums, direct results and divide/root setup.
//------------------------------------------------------------------------------
`default_nettype none

module cau_front
   import cau_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_accept,
   input  wire cau_req_type   req_item,
   output cau_stage_type      stage_out
);

   // Stage 1 registers
   logic          s1_valid_ff;
   cau_req_type   s1_req_ff;

   // Stage 2 registers
   logic                         s2_valid_ff;
   logic [2:0]                   s2_op_ff;
   logic signed [PROD_WIDTH-1:0] s2_p0_ff, s2_p1_ff, s2_p2_ff, s2_p3_ff, s2_p4_ff, s2_p5_ff;
   logic signed [WORD_WIDTH:0]   s2_dre_ff, s2_dim_ff;
   logic signed [WORD_WIDTH-1:0] s2_x_in, s2_y_in;
   logic signed [WORD_WIDTH:0]   s2_dre_in, s2_dim_in;

   // Stage 3 registers
   logic                        s3_valid_ff;
   logic [2:0]                  s3_op_ff;
   logic signed [SUM_WIDTH-1:0] s3_mre_ff, s3_mim_ff, s3_sre_ff, s3_sim_ff;
   logic [PROD_WIDTH-1:0]       s3_den_ff;
   cau_clamp_type               s3_cre_ff, s3_cim_ff;

   // Stage 4 registers
   logic                        s4_valid_ff;
   logic [2:0]                  s4_op_ff;
   cau_clamp_type               s4_re_ff, s4_im_ff;
   logic [PROD_WIDTH-1:0]       s4_nre_ff, s4_nim_ff, s4_den_ff, s4_sqv_ff;
   logic                        s4_neg_re_ff, s4_neg_im_ff;
   cau_clamp_type               s4_re_in, s4_im_in;
   logic signed [SUM_WIDTH-1:0] s4_abs_re_in, s4_abs_im_in;

   // Stage 5 register
   cau_stage_type stage_ff, stage_in;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 2: pick multiplier operands and form direct sums
   always_comb begin
      if (s1_req_ff.req_type == OP_SQR || s1_req_ff.req_type == OP_MOD) begin
         s2_x_in = s1_req_ff.a_real;
         s2_y_in = s1_req_ff.a_imag;
      end else begin
         s2_x_in = s1_req_ff.b_real;
         s2_y_in = s1_req_ff.b_imag;
      end
      s2_dre_in = '0;
      s2_dim_in = '0;
      case (s1_req_ff.req_type)
         OP_ADD: begin
            s2_dre_in = (WORD_WIDTH+1)'(s1_req_ff.a_real) + (WORD_WIDTH+1)'(s1_req_ff.b_real);
            s2_dim_in = (WORD_WIDTH+1)'(s1_req_ff.a_imag) + (WORD_WIDTH+1)'(s1_req_ff.b_imag);
         end
         OP_SUB: begin
            s2_dre_in = (WORD_WIDTH+1)'(s1_req_ff.a_real) - (WORD_WIDTH+1)'(s1_req_ff.b_real);
            s2_dim_in = (WORD_WIDTH+1)'(s1_req_ff.a_imag) - (WORD_WIDTH+1)'(s1_req_ff.b_imag);
         end
         OP_CNJ: begin
            s2_dre_in = (WORD_WIDTH+1)'(s1_req_ff.a_real);
            s2_dim_in = -((WORD_WIDTH+1)'(s1_req_ff.a_imag));
         end
         default: begin
            s2_dre_in = '0;
            s2_dim_in = '0;
         end
      endcase
   end

   // Stage 4: rescale products, take magnitudes
   always_comb begin
      if (s3_op_ff == OP_MUL || s3_op_ff == OP_SQR) begin
         s4_re_in = clamp_word(s3_mre_ff >>> FRAC_BITS);
         s4_im_in = clamp_word(s3_mim_ff >>> FRAC_BITS);
      end else begin
         s4_re_in = s3_cre_ff;
         s4_im_in = s3_cim_ff;
      end
      s4_abs_re_in = s3_sre_ff[SUM_WIDTH-1] ? -s3_sre_ff : s3_sre_ff;
      s4_abs_im_in = s3_sim_ff[SUM_WIDTH-1] ? -s3_sim_ff : s3_sim_ff;
   end

   // Stage 5: overflow check and divide/root seed
   always_comb begin
      stage_in          = stage_ff;
      stage_in.valid    = s4_valid_ff;
      stage_in.op       = s4_op_ff;
      stage_in.dir_re   = s4_re_ff.value;
      stage_in.dir_im   = s4_im_ff.value;
      stage_in.dir_sat  = s4_re_ff.sat | s4_im_ff.sat;
      stage_in.div_zero = (s4_den_ff == '0);
      stage_in.ovf_re   = {{PRE_SHIFT{1'b0}}, s4_nre_ff} >= {s4_den_ff, {PRE_SHIFT{1'b0}}};
      stage_in.ovf_im   = {{PRE_SHIFT{1'b0}}, s4_nim_ff} >= {s4_den_ff, {PRE_SHIFT{1'b0}}};
      stage_in.neg_re   = s4_neg_re_ff;
      stage_in.neg_im   = s4_neg_im_ff;
      stage_in.den      = s4_den_ff;
      stage_in.rem_re   = s4_nre_ff >> PRE_SHIFT;
      stage_in.rem_im   = s4_nim_ff >> PRE_SHIFT;
      stage_in.num_re   = {s4_nre_ff[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      stage_in.num_im   = {s4_nim_ff[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      stage_in.quo_re   = '0;
      stage_in.quo_im   = '0;
      stage_in.sq_v     = {{(SQ_IN_BITS-PROD_WIDTH){1'b0}}, s4_sqv_ff};
      stage_in.sq_rem   = '0;
      stage_in.sq_root  = '0;
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end

      s1_req_ff <= req_item;

      s2_op_ff  <= s1_req_ff.req_type;
      s2_p0_ff  <= PROD_WIDTH'(s1_req_ff.a_real) * PROD_WIDTH'(s2_x_in);
      s2_p1_ff  <= PROD_WIDTH'(s1_req_ff.a_imag) * PROD_WIDTH'(s2_y_in);
      s2_p2_ff  <= PROD_WIDTH'(s1_req_ff.a_imag) * PROD_WIDTH'(s2_x_in);
      s2_p3_ff  <= PROD_WIDTH'(s1_req_ff.a_real) * PROD_WIDTH'(s2_y_in);
      s2_p4_ff  <= PROD_WIDTH'(s1_req_ff.b_real) * PROD_WIDTH'(s1_req_ff.b_real);
      s2_p5_ff  <= PROD_WIDTH'(s1_req_ff.b_imag) * PROD_WIDTH'(s1_req_ff.b_imag);
      s2_dre_ff <= s2_dre_in;
      s2_dim_ff <= s2_dim_in;

      s3_op_ff  <= s2_op_ff;
      s3_mre_ff <= SUM_WIDTH'(s2_p0_ff) - SUM_WIDTH'(s2_p1_ff);
      s3_mim_ff <= SUM_WIDTH'(s2_p2_ff) + SUM_WIDTH'(s2_p3_ff);
      s3_sre_ff <= SUM_WIDTH'(s2_p0_ff) + SUM_WIDTH'(s2_p1_ff);
      s3_sim_ff <= SUM_WIDTH'(s2_p2_ff) - SUM_WIDTH'(s2_p3_ff);
      s3_den_ff <= s2_p4_ff[PROD_WIDTH-1:0] + s2_p5_ff[PROD_WIDTH-1:0];
      s3_cre_ff <= clamp_word(SUM_WIDTH'(s2_dre_ff));
      s3_cim_ff <= clamp_word(SUM_WIDTH'(s2_dim_ff));

      s4_op_ff     <= s3_op_ff;
      s4_re_ff     <= s4_re_in;
      s4_im_ff     <= s4_im_in;
      s4_nre_ff    <= s4_abs_re_in[PROD_WIDTH-1:0];
      s4_nim_ff    <= s4_abs_im_in[PROD_WIDTH-1:0];
      s4_neg_re_ff <= s3_sre_ff[SUM_WIDTH-1];
      s4_neg_im_ff <= s3_sim_ff[SUM_WIDTH-1];
      s4_den_ff    <= s3_den_ff;
      s4_sqv_ff    <= s3_sre_ff[PROD_WIDTH-1:0];

      stage_ff.op       <= stage_in.op;
      stage_ff.dir_re   <= stage_in.dir_re;
      stage_ff.dir_im   <= stage_in.dir_im;
      stage_ff.dir_sat  <= stage_in.dir_sat;
      stage_ff.div_zero <= stage_in.div_zero;
      stage_ff.ovf_re   <= stage_in.ovf_re;
      stage_ff.ovf_im   <= stage_in.ovf_im;
      stage_ff.neg_re   <= stage_in.neg_re;
      stage_ff.neg_im   <= stage_in.neg_im;
      stage_ff.den      <= stage_in.den;
      stage_ff.rem_re   <= stage_in.rem_re;
      stage_ff.rem_im   <= stage_in.rem_im;
      stage_ff.num_re   <= stage_in.num_re;
      stage_ff.num_im   <= stage_in.num_im;
      stage_ff.quo_re   <= stage_in.quo_re;
      stage_ff.quo_im   <= stage_in.quo_im;
      stage_ff.sq_v     <= stage_in.sq_v;
      stage_ff.sq_rem   <= stage_in.sq_rem;
      stage_ff.sq_root  <= stage_in.sq_root;
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

FILE: hdl/cau_step.sv
//------------------------------------------------------------------------------
// cau_step
// One quotient bit for both divide parts and one root bit, registered.
//------------------------------------------------------------------------------
`default_nettype none

module cau_step
   import cau_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cau_stage_type stage_in,
   output cau_stage_type      stage_out
);

   cau_stage_type           step_ff, step_in;
   logic [PROD_WIDTH:0]     trial_re, trial_im, den_ext;
   logic [SQ_REM_W+1:0]     sq_trial, sq_sub;
   logic                    take_re, take_im, take_sq;

   // Restoring divide and root steps
   always_comb begin
      step_in  = stage_in;
      den_ext  = {1'b0, stage_in.den};
      trial_re = {stage_in.rem_re, stage_in.num_re[DIV_STEPS-1]};
      trial_im = {stage_in.rem_im, stage_in.num_im[DIV_STEPS-1]};
      take_re  = trial_re >= den_ext;
      take_im  = trial_im >= den_ext;
      step_in.rem_re = take_re ? PROD_WIDTH'(trial_re - den_ext) : PROD_WIDTH'(trial_re);
      step_in.rem_im = take_im ? PROD_WIDTH'(trial_im - den_ext) : PROD_WIDTH'(trial_im);
      step_in.num_re = {stage_in.num_re[DIV_STEPS-2:0], 1'b0};
      step_in.num_im = {stage_in.num_im[DIV_STEPS-2:0], 1'b0};
      step_in.quo_re = {stage_in.quo_re[DIV_STEPS-2:0], take_re};
      step_in.quo_im = {stage_in.quo_im[DIV_STEPS-2:0], take_im};

      sq_trial = {stage_in.sq_rem, stage_in.sq_v[SQ_IN_BITS-1 -: 2]};
      sq_sub   = (SQ_REM_W+2)'({stage_in.sq_root, 2'b01});
      take_sq  = sq_trial >= sq_sub;
      step_in.sq_rem  = take_sq ? SQ_REM_W'(sq_trial - sq_sub) : SQ_REM_W'(sq_trial);
      step_in.sq_root = {stage_in.sq_root[ROOT_BITS-2:0], take_sq};
      step_in.sq_v    = {stage_in.sq_v[SQ_IN_BITS-3:0], 2'b00};
   end

   // Advance valid and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else begin
         step_ff.valid <= step_in.valid;
      end
      step_ff.op       <= step_in.op;
      step_ff.dir_re   <= step_in.dir_re;
      step_ff.dir_im   <= step_in.dir_im;
      step_ff.dir_sat  <= step_in.dir_sat;
      step_ff.div_zero <= step_in.div_zero;
      step_ff.ovf_re   <= step_in.ovf_re;
      step_ff.ovf_im   <= step_in.ovf_im;
      step_ff.neg_re   <= step_in.neg_re;
      step_ff.neg_im   <= step_in.neg_im;
      step_ff.den      <= step_in.den;
      step_ff.rem_re   <= step_in.rem_re;
      step_ff.rem_im   <= step_in.rem_im;
      step_ff.num_re   <= step_in.num_re;
      step_ff.num_im   <= step_in.num_im;
      step_ff.quo_re   <= step_in.quo_re;
      step_ff.quo_im   <= step_in.quo_im;
      step_ff.sq_v     <= step_in.sq_v;
      step_ff.sq_rem   <= step_in.sq_rem;
      step_ff.sq_root  <= step_in.sq_root;
   end

   assign stage_out = step_ff;

endmodule

`default_nettype wire

FILE: hdl/cau_back.sv
//------------------------------------------------------------------------------
// cau_back
// Select the final result by opcode, saturate and register the response.
//------------------------------------------------------------------------------
`default_nettype none

module cau_back
   import cau_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cau_stage_type stage_in,
   output logic               rsp_valid,
   output cau_rsp_type        rsp_item
);

   logic          rsp_valid_ff;
   cau_rsp_type   rsp_item_ff, rsp_item_in;
   cau_clamp_type q_re, q_im;

   // Form the result
   always_comb begin
      q_re = quo_word(stage_in.ovf_re, stage_in.neg_re, stage_in.quo_re);
      q_im = quo_word(stage_in.ovf_im, stage_in.neg_im, stage_in.quo_im);
      rsp_item_in.res_real = stage_in.dir_re;
      rsp_item_in.res_imag = stage_in.dir_im;
      rsp_item_in.status   = stage_in.dir_sat ? ST_SAT : ST_OK;
      case (stage_in.op)
         OP_DIV: begin
            if (stage_in.div_zero) begin
               rsp_item_in.res_real = '0;
               rsp_item_in.res_imag = '0;
               rsp_item_in.status   = ST_DIVZ;
            end else begin
               rsp_item_in.res_real = q_re.value;
               rsp_item_in.res_imag = q_im.value;
               rsp_item_in.status   = (q_re.sat | q_im.sat) ? ST_SAT : ST_OK;
            end
         end
         OP_MOD: begin
            rsp_item_in.res_imag = '0;
            if (stage_in.sq_root > ROOT_BITS'(WORD_MAX[WORD_WIDTH-1:0])) begin
               rsp_item_in.res_real = WORD_MAX[WORD_WIDTH-1:0];
               rsp_item_in.status   = ST_SAT;
            end else begin
               rsp_item_in.res_real = stage_in.sq_root[WORD_WIDTH-1:0];
               rsp_item_in.status   = ST_OK;
            end
         end
         default: begin
            rsp_item_in.res_real = stage_in.dir_re;
         end
      endcase
   end

   // Strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_in.valid;
      end
   end

   // Hold the result for its strobe cycle
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

FILE: hdl/complex_arith_unit.sv
//------------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add, subtract, multiply, divide, square, conjugate and
// modulus on signed Q15.16 operands.
//------------------------------------------------------------------------------
// A request accepted at the input passes 5 front stages, 33 divide/root bit
//   steps and the output register before its rsp_valid strobe.
// Throughput: one request per cycle; busy stays low and the receiver cannot
//   stall, so every request moves one stage per clock.
// Reset: synchronous reset clears all valid bits; requests in flight are lost.
//------------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit
   import cau_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire cau_req_type req_item,
   output logic             rsp_valid,
   output cau_rsp_type      rsp_item
);

   cau_stage_type stage_chain [0:DIV_STEPS];

   assign busy = 1'b0;

   // Operand products, sums and setup
   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (start & ~busy),
      .req_item   (req_item),
      .stage_out  (stage_chain[0])
   );

   // Divide and root bit steps
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      cau_step u_step (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage_chain[i]),
         .stage_out (stage_chain[i+1])
      );
   end

   // Result select and output register
   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (stage_chain[DIV_STEPS]),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

FILE: hdl/cau_checker.sv
//------------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module cau_checker
   import cau_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire cau_req_type req_item,
   input wire logic        rsp_valid,
   input wire cau_rsp_type rsp_item
);

   // Every strobe goes back to an accepted request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("response without request");

   // Divide-by-zero status only for a divide with zero divisor, and zero result
   a_divz_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_DIVZ) |->
         $past(req_item.req_type == OP_DIV && req_item.b_real == '0 &&
               req_item.b_imag == '0, PIPE_LATENCY))
      else $error("divide-by-zero status on wrong request");

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_DIVZ) |->
         (rsp_item.res_real == '0 && rsp_item.res_imag == '0))
      else $error("divide-by-zero result not zero");

   // Modulus has no imaginary part
   a_mod_imag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start && !busy && req_item.req_type == OP_MOD, PIPE_LATENCY))
         |-> rsp_item.res_imag == '0)
      else $error("modulus with nonzero imaginary part");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire
